>>> hdl/isba_pkg.sv
// Package for the 2x2 box-average image shrinker.
// Widths, reset values and register codes; no dependencies.
package isba_pkg;

  localparam int CFG_W = 12;   // configuration register width
  localparam int DIM_W = 14;   // effective frame dimension, holds up to 16383
  localparam int CH_W  = 8;    // one color channel
  localparam int PAIR_W = CH_W + 1;
  localparam int QUAD_W = CH_W + 2;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(2048);

  // configuration register indexes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic [PAIR_W-1:0] red;
    logic [PAIR_W-1:0] green;
    logic [PAIR_W-1:0] blue;
  } pair_sum_t;

endpackage

>>> hdl/image_shrink_2x_box_average.sv
// Top level of the 2x2 box-average image shrinker with its line store.
// Depends on isba_pkg.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+-----------------------------------------
//  input     | in_valid / in_ready     | in_red, in_green, in_blue
//  result    | out_valid / out_ready   | out_red, out_green, out_blue,
//            |                         |   out_last_in_frame
//  config    | cfg_we                  | cfg_index, cfg_wdata
//
// One item per cycle sustained while the output is not stalled. The line-store read
// and stage 1 are registered together; the output register takes their sum.
// Synchronous active-low reset clears counters and valids; the line store is not
// cleared (every odd-row read follows an even-row write of the same entry).
// A stalled output register holds the stage behind it, which then stops the input.
module image_shrink_2x_box_average
  import isba_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CH_W-1:0]  in_red,
  input  logic [CH_W-1:0]  in_green,
  input  logic [CH_W-1:0]  in_blue,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CH_W-1:0]  out_red,
  output logic [CH_W-1:0]  out_green,
  output logic [CH_W-1:0]  out_blue,
  output logic             out_last_in_frame,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  // configuration
  logic [CFG_W-1:0] width_cfg_r, height_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= DIM_RESET;
      height_cfg_r <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_cfg_r  <= cfg_wdata;
        REG_IMAGE_HEIGHT: height_cfg_r <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  logic [DIM_W-1:0] eff_w, eff_h, use_w, use_h, width_ext, height_ext;

  assign width_ext  = DIM_W'(width_cfg_r);
  assign height_ext = DIM_W'(height_cfg_r);

  always_comb begin
    if (width_ext == '0)                         eff_w = DIM_W'(1);
    else if (width_ext > DIM_W'(MAX_WIDTH))      eff_w = DIM_W'(MAX_WIDTH);
    else                                         eff_w = width_ext;
    if (height_ext == '0)                        eff_h = DIM_W'(1);
    else if (height_ext > DIM_W'(MAX_HEIGHT))    eff_h = DIM_W'(MAX_HEIGHT);
    else                                         eff_h = height_ext;
  end

  assign use_w = {eff_w[DIM_W-1:1], 1'b0};
  assign use_h = {eff_h[DIM_W-1:1], 1'b0};

  // raster position
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [DIM_W-1:0] col_ext, row_ext;
  logic             accept, col_wrap, row_wrap, in_area, line_wr, line_rd, last_pos;
  logic [AW-1:0]    line_idx;

  assign accept   = in_valid && in_ready;
  assign col_ext  = DIM_W'(col_r);
  assign row_ext  = DIM_W'(row_r);
  assign col_wrap = (col_ext >= eff_w - DIM_W'(1));
  assign row_wrap = (row_ext >= eff_h - DIM_W'(1));
  assign in_area  = (col_ext < use_w) && (row_ext < use_h);
  assign line_wr  = in_area && col_r[0] && !row_r[0];
  assign line_rd  = in_area && col_r[0] && row_r[0];
  assign line_idx = AW'(col_r >> 1);
  assign last_pos = (row_ext == use_h - DIM_W'(1)) && (col_ext == use_w - DIM_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col_r <= '0;
        row_r <= row_wrap ? '0 : row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  // first pixel of the current pair, and the pair sum with the second
  logic [3*CH_W-1:0] held_r;
  pair_sum_t         pair;

  assign pair.red   = PAIR_W'(held_r[3*CH_W-1:2*CH_W]) + PAIR_W'(in_red);
  assign pair.green = PAIR_W'(held_r[2*CH_W-1:CH_W])   + PAIR_W'(in_green);
  assign pair.blue  = PAIR_W'(held_r[CH_W-1:0])        + PAIR_W'(in_blue);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (accept && in_area && !col_r[0]) begin
      held_r <= {in_red, in_green, in_blue};
    end
  end

  // line store of even-row pair sums
  pair_sum_t line_mem [LINE_DEPTH];
  pair_sum_t line_q_r;

  always_ff @(posedge clk) begin
    if (accept && line_wr) begin
      line_mem[line_idx] <= pair;
    end
    if (accept && line_rd) begin
      line_q_r <= line_mem[line_idx];
    end
  end

  // stage 1: odd-row pair waiting for its line-store partner
  logic      s1_v_r, s1_last_r, s1_go;
  pair_sum_t s1_pair_r;

  assign s1_go    = s1_v_r && (!out_valid || out_ready);
  assign in_ready = !s1_v_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= accept && line_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && line_rd) begin
      s1_pair_r <= pair;
      s1_last_r <= last_pos;
    end
  end

  // output register
  logic              out_valid_r, out_last_r;
  logic [CH_W-1:0]   out_red_r, out_green_r, out_blue_r;
  logic [QUAD_W-1:0] quad_red, quad_green, quad_blue;

  assign quad_red   = QUAD_W'(line_q_r.red)   + QUAD_W'(s1_pair_r.red);
  assign quad_green = QUAD_W'(line_q_r.green) + QUAD_W'(s1_pair_r.green);
  assign quad_blue  = QUAD_W'(line_q_r.blue)  + QUAD_W'(s1_pair_r.blue);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_red_r   <= quad_red[QUAD_W-1:2];
      out_green_r <= quad_green[QUAD_W-1:2];
      out_blue_r  <= quad_blue[QUAD_W-1:2];
      out_last_r  <= s1_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_red           = out_red_r;
  assign out_green         = out_green_r;
  assign out_blue          = out_blue_r;
  assign out_last_in_frame = out_last_r;

  // checks
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_v_r && out_valid_r && !out_ready))
    else $error("input stalled without a full pipe");

  a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && col_wrap) |=> (col_r == '0))
    else $error("column counter did not wrap");

  a_read_odd_row: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && line_rd) |=> s1_v_r)
    else $error("odd-row pair not captured in stage 1");

  a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("unaccepted result dropped");

endmodule

>>> test/image_shrink_2x_box_average_test.sv
// Testbench for image_shrink_2x_box_average: random RGB frames of many sizes go in,
// each 2x2 average that comes out is checked against a predictor held in this file.
// Depends on isba_pkg and the block itself; reads no files.
module image_shrink_2x_box_average_test;
  timeunit 1ns;
  timeprecision 1ps;

  import isba_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int LINE_DEPTH  = DEF_MAX_WIDTH / 2;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            last;
  } shrunk_pixel_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [CH_W-1:0]  in_red;
  logic [CH_W-1:0]  in_green;
  logic [CH_W-1:0]  in_blue;
  logic             out_valid;
  logic             out_ready;
  logic [CH_W-1:0]  out_red;
  logic [CH_W-1:0]  out_green;
  logic [CH_W-1:0]  out_blue;
  logic             out_last_in_frame;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  // predictor state
  pair_sum_t         line_sums [LINE_DEPTH];
  logic [3*CH_W-1:0] first_of_pair;
  int                cur_col;
  int                cur_row;
  logic [CFG_W-1:0]  width_reg;
  logic [CFG_W-1:0]  height_reg;

  shrunk_pixel_t shrunk_q [$];
  int            mismatches;
  int            quiet_cycles;
  int            ready_hold;
  bit            steady_flow;

  image_shrink_2x_box_average u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_last_in_frame (out_last_in_frame),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int clamp_dim(logic [CFG_W-1:0] v, int hi);
    if (v == 0) return 1;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  // Consumes one pixel; returns 1 when it completes a 2x2 block.
  function automatic bit predict_shrink(input logic [CH_W-1:0] r, g, b,
                                        output shrunk_pixel_t res);
    int w;
    int h;
    int uw;
    int uh;
    int idx;
    pair_sum_t pair;
    logic [QUAD_W-1:0] qr;
    logic [QUAD_W-1:0] qg;
    logic [QUAD_W-1:0] qb;
    bit made;
    made = 1'b0;
    res = '0;
    w = clamp_dim(width_reg, DEF_MAX_WIDTH);
    h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
    uw = w & ~1;
    uh = h & ~1;
    if (cur_col < uw && cur_row < uh) begin
      if (cur_col % 2 == 0) begin
        first_of_pair = {r, g, b};
      end else begin
        idx = cur_col / 2;
        pair.red   = PAIR_W'(first_of_pair[23:16]) + PAIR_W'(r);
        pair.green = PAIR_W'(first_of_pair[15:8]) + PAIR_W'(g);
        pair.blue  = PAIR_W'(first_of_pair[7:0]) + PAIR_W'(b);
        if (cur_row % 2 == 0) begin
          line_sums[idx] = pair;
        end else begin
          qr = QUAD_W'(line_sums[idx].red) + QUAD_W'(pair.red);
          qg = QUAD_W'(line_sums[idx].green) + QUAD_W'(pair.green);
          qb = QUAD_W'(line_sums[idx].blue) + QUAD_W'(pair.blue);
          res.red   = qr[QUAD_W-1:2];
          res.green = qg[QUAD_W-1:2];
          res.blue  = qb[QUAD_W-1:2];
          res.last  = (cur_row == uh - 1) && (cur_col == uw - 1);
          made = 1'b1;
        end
      end
    end
    // row and frame ends use >= so a narrowed size mid-row still wraps
    if (cur_col >= w - 1) begin
      cur_col = 0;
      cur_row = (cur_row >= h - 1) ? 0 : cur_row + 1;
    end else begin
      cur_col = cur_col + 1;
    end
    return made;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    if (steady_flow) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_pixel(input logic [CH_W-1:0] r, g, b);
    int gap;
    shrunk_pixel_t res;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    do @(posedge clk); while (!in_ready);
    if (predict_shrink(r, g, b, res)) shrunk_q.push_back(res);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++)
      send_pixel(CH_W'($urandom_range(0, 255)), CH_W'($urandom_range(0, 255)),
                 CH_W'($urandom_range(0, 255)));
  endtask

  // Stop the input, let every expected item out, then give the pipe time
  // for items that made no result.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (shrunk_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [CFG_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) width_reg = value;
    else height_reg = value;
  endtask

  task automatic set_frame(input int w, input int h);
    cfg_write(REG_IMAGE_WIDTH, CFG_W'(w));
    cfg_write(REG_IMAGE_HEIGHT, CFG_W'(h));
  endtask

  // Starts under the reset size with the directed blocks; the width drops to 16
  // just before the last pixel of the first row, then the frame ends at 6x4.
  task automatic test_reset_size_start();
    int k;
    logic [3*CH_W-1:0] px;
    for (int row = 0; row < 2; row++) begin
      for (int col = 0; col < 16; col++) begin
        if (row == 0 && col == 15) cfg_write(REG_IMAGE_WIDTH, CFG_W'(16));
        k = row * 2 + col % 2;
        case (col / 2)
          0: px = {3{8'hFF}};
          1: px = '0;
          2: px = {8'(k), 8'(252 + k), 8'(3 * k)};  // averages truncate
          3: px = {(k % 2) ? 8'h55 : 8'hAA, (k % 2) ? 8'h7F : 8'h80,
                   (k == 0) ? 8'h01 : 8'h00};
          default: px = 24'($urandom());
        endcase
        send_pixel(px[23:16], px[15:8], px[7:0]);
      end
    end
    set_frame(6, 4);
    send_random(12);
  endtask

  task automatic test_mid_frame_changes();
    // narrow the width partway through an even row
    set_frame(8, 4);
    send_random(6);
    cfg_write(REG_IMAGE_WIDTH, CFG_W'(4));
    send_random(13);
    // shrink the height below the current row: that row is dropped, frame wraps
    set_frame(4, 8);
    send_random(16);
    cfg_write(REG_IMAGE_HEIGHT, CFG_W'(2));
    send_random(4);
  endtask

  // Zero acts as one, oversized settings clamp; large frames are cut short.
  task automatic test_dimension_extremes();
    int dims [7][2] = '{'{0, 0}, '{1, 6}, '{4095, 2}, '{2, 4095}, '{16, 1},
                        '{3, 3}, '{2, 2}};
    int count;
    for (int i = 0; i < 7; i++) begin
      steady_flow = (i % 2 == 1);
      set_frame(dims[i][0], dims[i][1]);
      count = clamp_dim(CFG_W'(dims[i][0]), DEF_MAX_WIDTH) *
              clamp_dim(CFG_W'(dims[i][1]), DEF_MAX_HEIGHT);
      send_random((count > 32) ? 32 : count);
    end
    steady_flow = 1'b0;
  endtask

  task automatic test_random_frames();
    int sent;
    int w;
    int h;
    int count;
    sent = 0;
    while (sent < 580) begin
      w = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 17) : 2 * $urandom_range(1, 8);
      h = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 2 * $urandom_range(1, 4);
      count = w * h * $urandom_range(1, 2);
      steady_flow = ($urandom_range(0, 3) == 0);
      set_frame(w, h);
      send_random(count);
      sent += count;
    end
    steady_flow = 1'b0;
  endtask

  // result side: random back-pressure
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
      out_ready  <= 1'b0;
      ready_hold <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    shrunk_pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (shrunk_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("unexpected item: got %0d %0d %0d last %0b",
                   out_red, out_green, out_blue, out_last_in_frame);
      end else begin
        want = shrunk_q.pop_front();
        if (out_red !== want.red || out_green !== want.green ||
            out_blue !== want.blue || out_last_in_frame !== want.last) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("item mismatch: expected %0d %0d %0d last %0b, got %0d %0d %0d last %0b",
                     want.red, want.green, want.blue, want.last,
                     out_red, out_green, out_blue, out_last_in_frame);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_red       = '0;
    in_green     = '0;
    in_blue      = '0;
    out_ready    = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_IMAGE_WIDTH;
    cfg_wdata    = '0;
    mismatches   = 0;
    quiet_cycles = 0;
    ready_hold   = 0;
    steady_flow  = 1'b0;
    for (int i = 0; i < LINE_DEPTH; i++) line_sums[i] = '0;
    first_of_pair = '0;
    cur_col    = 0;
    cur_row    = 0;
    width_reg  = DIM_RESET;
    height_reg = DIM_RESET;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_size_start();
    test_mid_frame_changes();
    test_dimension_extremes();
    test_random_frames();

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && shrunk_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/isba_pkg.sv
hdl/image_shrink_2x_box_average.sv
test/image_shrink_2x_box_average_test.sv
